[sv/gf_pkg.sv]
// Shared types, constants and codes for the distance-weighted gap fill block.
package gf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF       = 256;
    localparam int MAX_ROWS_DEF       = 256;
    localparam int DIST_FRAC_BITS_DEF = 8;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_FLAG = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_COPIED = 2'd0;
    localparam logic [1:0] ST_FILLED = 2'd1;
    localparam logic [1:0] ST_MASKED = 2'd2;
    localparam logic [1:0] ST_FEW    = 2'd3;

    // Quotient bits of the final division (result fits in 15 bits)
    localparam int QUOT_W = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENT,
        S_PAIR,
        S_PROBE,
        S_PEVAL,
        S_SQ_LD,
        S_SQ_RUN,
        S_SQ_END,
        S_MUL,
        S_DIV_LD,
        S_DIV_RUN,
        S_FILL
    } gf_state_t;

    typedef struct packed {
        logic load;
        logic query;
        logic center;
        logic init_search;
        logic next_ring;
        logic next_a;
        logic load_pair;
        logic next_k;
        logic rd_probe;
        logic take;
        logic sq_load;
        logic sq_step;
        logic sq_store;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic emit_fill;
        logic emit_few;
    } gf_cmd_t;

    typedef struct packed {
        logic cen_term;
        logic ring_over;
        logic a_over;
        logic pair_skip;
        logic in_bounds;
        logic k_last;
        logic hit;
        logic n3;
        logic sq_last;
        logic dv_last;
        logic i_last;
    } gf_stat_t;

endpackage

[sv/gf_ctrl.sv]
// Controller state machine for the gap fill: sequences center check, ring search and math.
module gf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             opcode,
    input  gf_pkg::gf_stat_t stat,
    output logic             busy,
    output gf_pkg::gf_cmd_t  cmd
);

    gf_pkg::gf_state_t state_reg;
    gf_pkg::gf_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gf_pkg::S_IDLE:
            begin
                if (start && opcode == gf_pkg::OP_FILL)
                begin
                    state_next = gf_pkg::S_CENT;
                end
            end
            gf_pkg::S_CENT:
            begin
                state_next = stat.cen_term ? gf_pkg::S_IDLE : gf_pkg::S_PAIR;
            end
            gf_pkg::S_PAIR:
            begin
                if (stat.ring_over)
                begin
                    state_next = gf_pkg::S_IDLE;
                end
                else if (!stat.a_over && !stat.pair_skip)
                begin
                    state_next = gf_pkg::S_PROBE;
                end
            end
            gf_pkg::S_PROBE:
            begin
                if (stat.in_bounds)
                begin
                    state_next = gf_pkg::S_PEVAL;
                end
                else if (stat.k_last)
                begin
                    state_next = gf_pkg::S_PAIR;
                end
            end
            gf_pkg::S_PEVAL:
            begin
                if (stat.hit && stat.n3)
                begin
                    state_next = gf_pkg::S_SQ_LD;
                end
                else
                begin
                    state_next = stat.k_last ? gf_pkg::S_PAIR : gf_pkg::S_PROBE;
                end
            end
            gf_pkg::S_SQ_LD:
            begin
                state_next = gf_pkg::S_SQ_RUN;
            end
            gf_pkg::S_SQ_RUN:
            begin
                if (stat.sq_last)
                begin
                    state_next = gf_pkg::S_SQ_END;
                end
            end
            gf_pkg::S_SQ_END:
            begin
                state_next = stat.i_last ? gf_pkg::S_MUL : gf_pkg::S_SQ_LD;
            end
            gf_pkg::S_MUL:
            begin
                if (stat.i_last)
                begin
                    state_next = gf_pkg::S_DIV_LD;
                end
            end
            gf_pkg::S_DIV_LD:
            begin
                state_next = gf_pkg::S_DIV_RUN;
            end
            gf_pkg::S_DIV_RUN:
            begin
                if (stat.dv_last)
                begin
                    state_next = gf_pkg::S_FILL;
                end
            end
            gf_pkg::S_FILL:
            begin
                state_next = gf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gf_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != gf_pkg::S_IDLE);
        case (state_reg)
            gf_pkg::S_IDLE:
            begin
                cmd.load  = start && opcode == gf_pkg::OP_LOAD;
                cmd.query = start && opcode == gf_pkg::OP_FILL;
            end
            gf_pkg::S_CENT:
            begin
                cmd.center      = 1'b1;
                cmd.init_search = !stat.cen_term;
            end
            gf_pkg::S_PAIR:
            begin
                if (stat.ring_over)
                begin
                    cmd.emit_few = 1'b1;
                end
                else if (stat.a_over)
                begin
                    cmd.next_ring = 1'b1;
                end
                else if (stat.pair_skip)
                begin
                    cmd.next_a = 1'b1;
                end
                else
                begin
                    cmd.load_pair = 1'b1;
                end
            end
            gf_pkg::S_PROBE:
            begin
                if (stat.in_bounds)
                begin
                    cmd.rd_probe = 1'b1;
                end
                else if (stat.k_last)
                begin
                    cmd.next_a = 1'b1;
                end
                else
                begin
                    cmd.next_k = 1'b1;
                end
            end
            gf_pkg::S_PEVAL:
            begin
                cmd.take = 1'b1;
                if (!(stat.hit && stat.n3))
                begin
                    cmd.next_a = stat.k_last;
                    cmd.next_k = !stat.k_last;
                end
            end
            gf_pkg::S_SQ_LD:
            begin
                cmd.sq_load = 1'b1;
            end
            gf_pkg::S_SQ_RUN:
            begin
                cmd.sq_step = 1'b1;
            end
            gf_pkg::S_SQ_END:
            begin
                cmd.sq_store = 1'b1;
            end
            gf_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            gf_pkg::S_DIV_LD:
            begin
                cmd.div_load = 1'b1;
            end
            gf_pkg::S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
            end
            gf_pkg::S_FILL:
            begin
                cmd.emit_fill = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/gf_dp.sv]
// Datapath for the gap fill: pixel store, ring walker, square root, blend and divider.
module gf_dp #(
    parameter int MAX_COLS       = gf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS       = gf_pkg::MAX_ROWS_DEF,
    parameter int DIST_FRAC_BITS = gf_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gf_pkg::gf_cmd_t    cmd,
    output gf_pkg::gf_stat_t   stat,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic signed [15:0] pixel_value,
    input  logic               in_mask,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] filled_value,
    output logic [14:0]        fill_distance,
    output logic [1:0]         fill_status
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RA_W   = $clog2(MAX_ROWS);
    localparam int CA_W   = $clog2(MAX_COLS);
    localparam int OFF_W  = $clog2(MAX_ROWS + MAX_COLS);
    localparam int A_W    = OFF_W + 1;
    localparam int PW     = ((OFF_W > 8) ? OFF_W : 8) + 2;
    localparam int SQ_W   = 2 * OFF_W + 1;
    localparam int RT_W   = (SQ_W + 2 * DIST_FRAC_BITS + 1) / 2;
    localparam int XE_W   = 2 * RT_W;
    localparam int REM_W  = RT_W + 3;
    localparam int D_W    = RT_W + 2;
    localparam int NUM_W  = D_W + 17;
    localparam int DS_W   = D_W + 2 + gf_pkg::QUOT_W - 1;
    localparam int FQ_W   = D_W - DIST_FRAC_BITS - 2;
    localparam int FD_W   = ((FQ_W + 4) > 16) ? (FQ_W + 4) : 16;
    localparam int CNT_W  = $clog2(((RT_W > gf_pkg::QUOT_W) ? RT_W : gf_pkg::QUOT_W) + 1);
    localparam int LIM_W  = 14;

    // Configuration registers
    logic [8:0]  cols_reg;
    logic [8:0]  rows_reg;
    logic [15:0] flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 9'd256;
            rows_reg <= 9'd256;
            flag_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gf_pkg::REG_COLS: cols_reg <= cfg_data[8:0];
                gf_pkg::REG_ROWS: rows_reg <= cfg_data[8:0];
                gf_pkg::REG_FLAG: flag_reg <= cfg_data;
                default:          flag_reg <= flag_reg;
            endcase
        end
    end

    // Clamp image size to the store
    logic [LIM_W-1:0] cols_c;
    logic [LIM_W-1:0] rows_c;
    logic [A_W-1:0]   last_ring;

    always_comb
    begin
        if (cols_reg == '0)
            cols_c = LIM_W'(1);
        else if (LIM_W'(cols_reg) > LIM_W'(MAX_COLS))
            cols_c = LIM_W'(MAX_COLS);
        else
            cols_c = LIM_W'(cols_reg);
        if (rows_reg == '0)
            rows_c = LIM_W'(1);
        else if (LIM_W'(rows_reg) > LIM_W'(MAX_ROWS))
            rows_c = LIM_W'(MAX_ROWS);
        else
            rows_c = LIM_W'(rows_reg);
        last_ring = A_W'(rows_c) + A_W'(cols_c) - A_W'(2);
    end

    // Query position and search state
    logic [7:0]     qrow_reg;
    logic [7:0]     qcol_reg;
    logic [A_W-1:0] ring_reg;
    logic [A_W-1:0] a_reg;
    logic [2:0]     k_reg;
    logic [2:0]     n_reg;
    logic [1:0]     i_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] sqs_reg [4];
    logic [14:0]    vals_reg [4];
    logic [RT_W-1:0] dist_reg [4];
    logic [D_W-1:0] dsum_reg;

    logic [A_W-1:0] b_cur;
    logic [2:0]     kk;
    logic           both_nz;
    logic [A_W-1:0] off_r;
    logic [A_W-1:0] off_c;
    logic           neg_r;
    logic           neg_c;
    logic [PW-1:0]  rr;
    logic [PW-1:0]  cc;
    logic [A_W-1:0] half_up;

    always_comb
    begin
        b_cur   = ring_reg - a_reg;
        both_nz = (a_reg != '0) && (b_cur != '0);
        kk      = both_nz ? k_reg : {k_reg[1], 1'b0, k_reg[0]};
        off_r   = kk[2] ? b_cur : a_reg;
        off_c   = kk[2] ? a_reg : b_cur;
        neg_r   = (kk[1:0] == 2'd1) || (kk[1:0] == 2'd2);
        neg_c   = (kk[1:0] == 2'd1) || (kk[1:0] == 2'd3);
        rr      = neg_r ? PW'(qrow_reg) - PW'(off_r) : PW'(qrow_reg) + PW'(off_r);
        cc      = neg_c ? PW'(qcol_reg) - PW'(off_c) : PW'(qcol_reg) + PW'(off_c);
        half_up = (ring_reg + A_W'(1)) >> 1;
    end

    // Pixel store with registered read
    logic [16:0]       mem [DEPTH];
    logic [16:0]       rd_reg;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       row_x;
    logic [15:0]       col_x;
    logic [15:0]       rr_x;
    logic [15:0]       cc_x;

    always_comb
    begin
        row_x = 16'(row);
        col_x = 16'(col);
        rr_x  = 16'(rr);
        cc_x  = 16'(cc);
        waddr = ADDR_W'(row_x[RA_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(col_x[CA_W-1:0]);
        if (cmd.query)
            raddr = waddr;
        else
            raddr = ADDR_W'(rr_x[RA_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(cc_x[CA_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && LIM_W'(row) < LIM_W'(MAX_ROWS) && LIM_W'(col) < LIM_W'(MAX_COLS))
        begin
            mem[waddr] <= {in_mask, pixel_value};
        end
        if (cmd.query || cmd.rd_probe)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // Status toward the controller
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_pos;
    logic             q_oob;

    always_comb
    begin
        rd_pos         = rd_reg[16] && !rd_reg[15] && (rd_reg[14:0] != '0);
        q_oob          = LIM_W'(qrow_reg) >= rows_c || LIM_W'(qcol_reg) >= cols_c;
        stat.cen_term  = q_oob || !rd_reg[16] || rd_pos;
        stat.ring_over = ring_reg > last_ring;
        stat.a_over    = a_reg > ring_reg;
        stat.pair_skip = ring_reg[0] && (a_reg == half_up);
        stat.in_bounds = !rr[PW-1] && !cc[PW-1]
                         && rr < PW'(rows_c) && cc < PW'(cols_c);
        stat.k_last    = (both_nz && a_reg != b_cur) ? (k_reg == 3'd7) : (k_reg == 3'd3);
        stat.hit       = rd_pos;
        stat.n3        = n_reg == 3'd3;
        stat.sq_last   = cnt_reg == CNT_W'(RT_W - 1);
        stat.dv_last   = cnt_reg == CNT_W'(gf_pkg::QUOT_W - 1);
        stat.i_last    = i_reg == 2'd3;
    end

    // Square root, product sum and division registers
    logic [XE_W-1:0]   x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [RT_W-1:0]   root_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DS_W-1:0]   drem_reg;
    logic [DS_W-1:0]   dsh_reg;
    logic [gf_pkg::QUOT_W-1:0] quot_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [NUM_W-1:0]  prod;
    logic [D_W+1:0]    div3;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], x_reg[XE_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        prod   = NUM_W'(vals_reg[i_reg]) * NUM_W'(dsum_reg - D_W'(dist_reg[i_reg]));
        div3   = (D_W + 2)'(dsum_reg) + ((D_W + 2)'(dsum_reg) << 1);
    end

    // Search and arithmetic sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            a_reg    <= '0;
            k_reg    <= '0;
            n_reg    <= '0;
            i_reg    <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Start the ring walk at ring one, a = 0
            if (cmd.init_search)
            begin
                ring_reg <= A_W'(1);
                a_reg    <= '0;
                k_reg    <= '0;
                n_reg    <= '0;
                i_reg    <= '0;
            end
            if (cmd.next_ring)
            begin
                ring_reg <= ring_reg + A_W'(1);
                a_reg    <= (ring_reg + A_W'(1)) >> 1;
            end
            if (cmd.next_a)
            begin
                a_reg <= a_reg + A_W'(1);
                k_reg <= '0;
            end
            if (cmd.load_pair)
            begin
                k_reg <= '0;
            end
            if (cmd.next_k)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (cmd.take && rd_pos)
            begin
                n_reg <= n_reg + 3'd1;
            end
            if (cmd.sq_load || cmd.div_load)
            begin
                cnt_reg <= '0;
            end
            if (cmd.sq_step || cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.sq_store || cmd.mul_step)
            begin
                i_reg <= i_reg + 2'd1;
            end
        end
    end

    // Payload registers of the search and math
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            qrow_reg <= row;
            qcol_reg <= col;
        end
        if (cmd.init_search)
        begin
            dsum_reg <= '0;
            num_reg  <= '0;
        end
        if (cmd.load_pair)
        begin
            sq_reg <= SQ_W'(a_reg[OFF_W-1:0]) * SQ_W'(a_reg[OFF_W-1:0])
                    + SQ_W'(b_cur[OFF_W-1:0]) * SQ_W'(b_cur[OFF_W-1:0]);
        end
        // Keep a found neighbour
        if (cmd.take && rd_pos)
        begin
            vals_reg[n_reg[1:0]] <= rd_reg[14:0];
            sqs_reg[n_reg[1:0]]  <= sq_reg;
        end
        // One root bit per cycle
        if (cmd.sq_load)
        begin
            x_reg    <= XE_W'(sqs_reg[i_reg]) << (2 * DIST_FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sq_step)
        begin
            x_reg <= x_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
        if (cmd.sq_store)
        begin
            dist_reg[i_reg] <= root_reg;
            dsum_reg        <= dsum_reg + D_W'(root_reg);
        end
        // Accumulate one weighted value per cycle
        if (cmd.mul_step)
        begin
            num_reg <= num_reg + prod;
        end
        // One quotient bit per cycle
        if (cmd.div_load)
        begin
            drem_reg <= DS_W'(num_reg);
            dsh_reg  <= DS_W'(div3) << (gf_pkg::QUOT_W - 1);
            quot_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (drem_reg >= dsh_reg)
            begin
                drem_reg <= drem_reg - dsh_reg;
                quot_reg <= {quot_reg[gf_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[gf_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Mean distance times ten, saturated
    logic [FQ_W-1:0] fq;
    logic [FD_W-1:0] fd;
    logic [14:0]     fd_sat;

    always_comb
    begin
        fq     = FQ_W'(dsum_reg >> (DIST_FRAC_BITS + 2));
        fd     = (FD_W'(fq) << 3) + (FD_W'(fq) << 1);
        fd_sat = (fd > FD_W'(32767)) ? 15'h7FFF : fd[14:0];
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= (cmd.center && stat.cen_term) || cmd.emit_fill || cmd.emit_few;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.center)
        begin
            fill_distance <= '0;
            if (q_oob || !rd_reg[16])
            begin
                filled_value <= flag_reg;
                fill_status  <= gf_pkg::ST_MASKED;
            end
            else
            begin
                filled_value <= rd_reg[15:0];
                fill_status  <= gf_pkg::ST_COPIED;
            end
        end
        if (cmd.emit_few)
        begin
            filled_value  <= flag_reg;
            fill_distance <= '0;
            fill_status   <= gf_pkg::ST_FEW;
        end
        if (cmd.emit_fill)
        begin
            filled_value  <= quot_reg;
            fill_distance <= fd_sat;
            fill_status   <= gf_pkg::ST_FILLED;
        end
    end

endmodule

[sv/distance_weighted_gap_fill.sv]
// Top level of the distance-weighted gap fill: controller plus datapath.
// Loads write the store from idle; busy stays low. A fill decided at its center pixel
// strobes done after the registered store read and the center check. A search steps
// through rings and pairs and reads the store for each probe inside the image, then takes
// the square roots, accumulates and divides. busy is high until done; no stall.
// Reset clears control and config; the pixel store holds no reset value.
module distance_weighted_gap_fill #(
    parameter int MAX_COLS       = gf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS       = gf_pkg::MAX_ROWS_DEF,
    parameter int DIST_FRAC_BITS = gf_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic signed [15:0] pixel_value,
    input  logic               in_mask,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] filled_value,
    output logic [14:0]        fill_distance,
    output logic [1:0]         fill_status
);

    gf_pkg::gf_cmd_t  cmd;
    gf_pkg::gf_stat_t stat;

    // Sequence the work
    gf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Store and arithmetic
    gf_dp #(
        .MAX_COLS       (MAX_COLS),
        .MAX_ROWS       (MAX_ROWS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .row           (row),
        .col           (col),
        .pixel_value   (pixel_value),
        .in_mask       (in_mask),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .filled_value  (filled_value),
        .fill_distance (fill_distance),
        .fill_status   (fill_status)
    );

endmodule
